FILE: hdl/ihrl_pkg.sv
// Shared types, constants and character decode for the Intel HEX record loader.
`timescale 1ns / 1ps
package ihrl_pkg;

	// Longest run of hex digits accepted on one line.
	localparam int MAX_LINE_CHARS = 530;
	localparam int DIGIT_W        = $clog2(MAX_LINE_CHARS + 1);
	localparam int IDX_W          = DIGIT_W - 1;
	localparam int CMP_W          = ((DIGIT_W > 10) ? DIGIT_W : 10) + 1;

	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_LC_OFS = 8'd87;
	localparam logic [7:0] CHAR_UC_OFS = 8'd55;

	// Record types
	localparam logic [7:0] REC_DATA = 8'h00;
	localparam logic [7:0] REC_EOF  = 8'h01;
	localparam logic [7:0] REC_ESA  = 8'h02;
	localparam logic [7:0] REC_ELA  = 8'h04;

	// Byte positions within a record
	localparam int BYTE_COUNT   = 0;
	localparam int BYTE_ADDR_HI = 1;
	localparam int BYTE_ADDR_LO = 2;
	localparam int BYTE_TYPE    = 3;
	localparam int BYTE_EXT_HI  = 4;
	localparam int BYTE_EXT_LO  = 5;

	// Minimum digit count of an extended address record
	localparam int EXT_MIN_DIGITS = 12;
	localparam int HDR_DIGITS     = 8;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_DONE  = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		PH_COLON  = 4'b0001,
		PH_RECORD = 4'b0010,
		PH_SKIP   = 4'b0100,
		PH_STOP   = 4'b1000
	} phase_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] write_offset;
		logic [7:0]  byte_value;
		logic [31:0] extent;
	} ihrl_result_t;

	// {valid, nibble}
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		logic [7:0] v;
		v = 8'h00;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c - 8'h30;
			return {1'b1, v[3:0]};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = c - CHAR_LC_OFS;
			return {1'b1, v[3:0]};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = c - CHAR_UC_OFS;
			return {1'b1, v[3:0]};
		end
		return 5'b0_0000;
	endfunction

endpackage

FILE: hdl/ihrl_in_if.sv
// Character input channel of the Intel HEX record loader.
`timescale 1ns / 1ps
interface ihrl_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       stream_end;

	modport source (output valid, output ch, output stream_end, input ready);
	modport sink (input valid, input ch, input stream_end, output ready);
endinterface

FILE: hdl/ihrl_out_if.sv
// Result channel of the Intel HEX record loader.
`timescale 1ns / 1ps
interface ihrl_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] write_offset;
	logic [7:0]  byte_value;
	logic [31:0] extent;

	modport source (output valid, output kind, output write_offset, output byte_value,
		output extent, input ready);
	modport sink (input valid, input kind, input write_offset, input byte_value,
		input extent, output ready);
endinterface

FILE: hdl/ihrl_out_reg.sv
// Output register for result words; frees up as the receiver takes its word.
`timescale 1ns / 1ps
module ihrl_out_reg
	import ihrl_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  ihrl_result_t  res,
	output logic          can_load,
	ihrl_out_if.source    result
);

	logic         valid_q;
	ihrl_result_t data_q;

	assign can_load = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && load) begin
			data_q <= res;
		end
	end

	assign result.valid        = valid_q;
	assign result.kind         = data_q.kind;
	assign result.write_offset = data_q.write_offset;
	assign result.byte_value   = data_q.byte_value;
	assign result.extent       = data_q.extent;

endmodule

FILE: hdl/intel_hex_record_loader.sv
// Intel HEX record loader: parses hex text into data byte writes.
// Usage:
//   text   - one ASCII character per word (ch), or an end-of-input marker
//            (stream_end = 1, ch ignored).
//   result - kind 0 data write (write_offset, byte_value), kind 1 load
//            complete (extent), kind 2 format error.
// Each accepted character is decoded in the cycle it is accepted; any word it
// produces sits in the output register from the next cycle. Throughput is one
// character per cycle while the receiver does not stall. The limit is the single
// per-character update of the parse state (a 32-bit subtract and compare for
// the data address).
// text.ready stays high while the output register is empty or being taken;
// when the receiver stalls with a word held, input stalls too and nothing is
// lost. After a completion or an error word the block swallows all further
// input without results until reset.
// Reset (arst_n low) returns to waiting for a ':' with linear addressing and
// zero bases, and empties the output register.
`timescale 1ns / 1ps
module intel_hex_record_loader
	import ihrl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	ihrl_in_if.sink    text,
	ihrl_out_if.source result
);

	phase_t               phase_q, phase_nx;
	logic [DIGIT_W-1:0]   digit_q, digit_nx;
	logic [3:0]           hi_nib_q, hi_nib_nx;
	logic [7:0]           count_q, count_nx;
	logic [15:0]          rec_addr_q, rec_addr_nx;
	logic [7:0]           rec_type_q, rec_type_nx;
	logic [15:0]          ext_word_q, ext_word_nx;
	logic                 seg_mode_q, seg_mode_nx;
	logic [15:0]          seg_base_q, seg_base_nx;
	logic [15:0]          lin_base_q, lin_base_nx;
	logic [31:0]          first_addr_q, first_addr_nx;
	logic                 have_first_q, have_first_nx;
	logic [31:0]          wptr_q, wptr_nx;
	logic [31:0]          max_ext_q, max_ext_nx;

	logic                 can_load;
	logic                 accept;
	logic                 emit;
	ihrl_result_t         res;

	logic [4:0]           nib_dec;
	logic                 nib_ok;
	logic [3:0]           nib;
	logic [7:0]           byte_val;
	logic [IDX_W-1:0]     byte_idx;
	logic [CMP_W-1:0]     di_ext;
	logic [CMP_W-1:0]     need;
	logic [CMP_W-1:0]     need_x;
	logic                 is_ext;
	logic                 short_rec;
	logic                 in_range;
	logic [31:0]          phys;
	logic [31:0]          first_eff;
	logic [31:0]          wp_new;
	logic [31:0]          wp_inc;
	logic                 is_eol;

	assign text.ready = can_load;
	assign accept     = text.valid && can_load;

	assign nib_dec  = hex_nibble(text.ch);
	assign nib_ok   = nib_dec[4];
	assign nib      = nib_dec[3:0];
	assign byte_val = {hi_nib_q, nib};
	assign byte_idx = digit_q[DIGIT_W-1:1];
	assign is_eol   = (text.ch == CHAR_CR) || (text.ch == CHAR_LF);

	// Line length check for closing a record
	assign is_ext    = (rec_type_q == REC_ESA) || (rec_type_q == REC_ELA);
	assign di_ext    = CMP_W'(digit_q);
	assign need      = CMP_W'(HDR_DIGITS) + CMP_W'({count_q, 1'b0});
	assign need_x    = (is_ext && need < CMP_W'(EXT_MIN_DIGITS)) ? CMP_W'(EXT_MIN_DIGITS) : need;
	assign short_rec = di_ext < need_x;
	assign in_range  = CMP_W'(byte_idx) < (CMP_W'(count_q) + CMP_W'(BYTE_EXT_HI));

	// Segment bases, shifted left four bits, are ORed into the record address
	assign phys = seg_mode_q ? ({12'h000, seg_base_q, 4'h0} | {16'h0000, rec_addr_q})
	                         : {lin_base_q, rec_addr_q};
	assign first_eff = have_first_q ? first_addr_q : phys;
	assign wp_new    = phys - first_eff;
	assign wp_inc    = wptr_q + 32'd1;

	always_comb begin
		phase_nx      = phase_q;
		digit_nx      = digit_q;
		hi_nib_nx     = hi_nib_q;
		count_nx      = count_q;
		rec_addr_nx   = rec_addr_q;
		rec_type_nx   = rec_type_q;
		ext_word_nx   = ext_word_q;
		seg_mode_nx   = seg_mode_q;
		seg_base_nx   = seg_base_q;
		lin_base_nx   = lin_base_q;
		first_addr_nx = first_addr_q;
		have_first_nx = have_first_q;
		wptr_nx       = wptr_q;
		max_ext_nx    = max_ext_q;
		emit          = 1'b0;
		res           = '0;
		res.kind      = KIND_ERROR;

		if (accept) begin
			unique case (phase_q)
				PH_STOP: begin
				end
				PH_COLON: begin
					if (text.stream_end || text.ch != CHAR_COLON) begin
						emit     = 1'b1;
						phase_nx = PH_STOP;
					end else begin
						phase_nx  = PH_RECORD;
						digit_nx  = '0;
						hi_nib_nx = 4'h0;
					end
				end
				PH_SKIP: begin
					if (text.stream_end) begin
						emit     = 1'b1;
						phase_nx = PH_STOP;
					end else if (text.ch == CHAR_LF) begin
						phase_nx = PH_COLON;
					end
				end
				PH_RECORD: begin
					if (text.stream_end || is_eol) begin
						if (short_rec) begin
							emit     = 1'b1;
							phase_nx = PH_STOP;
						end else if (rec_type_q == REC_EOF) begin
							emit       = 1'b1;
							res.kind   = KIND_DONE;
							res.extent = max_ext_q;
							phase_nx   = PH_STOP;
						end else if (text.stream_end) begin
							emit     = 1'b1;
							phase_nx = PH_STOP;
						end else begin
							if (rec_type_q == REC_ESA) begin
								seg_mode_nx = 1'b1;
								seg_base_nx = ext_word_q;
							end else if (rec_type_q == REC_ELA) begin
								seg_mode_nx = 1'b0;
								lin_base_nx = ext_word_q;
							end
							phase_nx = (text.ch == CHAR_LF) ? PH_COLON : PH_SKIP;
						end
					end else if (!nib_ok || di_ext >= CMP_W'(MAX_LINE_CHARS)) begin
						emit     = 1'b1;
						phase_nx = PH_STOP;
					end else if (!digit_q[0]) begin
						hi_nib_nx = nib;
						digit_nx  = digit_q + DIGIT_W'(1);
					end else begin
						digit_nx = digit_q + DIGIT_W'(1);
						if (byte_idx == IDX_W'(BYTE_COUNT)) begin
							count_nx = byte_val;
						end else if (byte_idx == IDX_W'(BYTE_ADDR_HI)) begin
							rec_addr_nx[15:8] = byte_val;
						end else if (byte_idx == IDX_W'(BYTE_ADDR_LO)) begin
							rec_addr_nx[7:0] = byte_val;
						end else if (byte_idx == IDX_W'(BYTE_TYPE)) begin
							rec_type_nx = byte_val;
							if (byte_val == REC_DATA) begin
								if (!have_first_q) begin
									first_addr_nx = phys;
									have_first_nx = 1'b1;
								end
								wptr_nx = wp_new;
								if (wp_new > max_ext_q) begin
									max_ext_nx = wp_new;
								end
							end
						end else if (is_ext) begin
							if (byte_idx == IDX_W'(BYTE_EXT_HI)) begin
								ext_word_nx[15:8] = byte_val;
							end else if (byte_idx == IDX_W'(BYTE_EXT_LO)) begin
								ext_word_nx[7:0] = byte_val;
							end
						end else if (rec_type_q == REC_DATA && in_range) begin
							emit             = 1'b1;
							res.kind         = KIND_DATA;
							res.write_offset = wptr_q;
							res.byte_value   = byte_val;
							wptr_nx          = wp_inc;
							if (wp_inc > max_ext_q) begin
								max_ext_nx = wp_inc;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_COLON;
			digit_q      <= '0;
			hi_nib_q     <= 4'h0;
			count_q      <= 8'h00;
			rec_addr_q   <= 16'h0000;
			rec_type_q   <= 8'h00;
			ext_word_q   <= 16'h0000;
			seg_mode_q   <= 1'b0;
			seg_base_q   <= 16'h0000;
			lin_base_q   <= 16'h0000;
			first_addr_q <= 32'h0;
			have_first_q <= 1'b0;
			wptr_q       <= 32'h0;
			max_ext_q    <= 32'h0;
		end else begin
			phase_q      <= phase_nx;
			digit_q      <= digit_nx;
			hi_nib_q     <= hi_nib_nx;
			count_q      <= count_nx;
			rec_addr_q   <= rec_addr_nx;
			rec_type_q   <= rec_type_nx;
			ext_word_q   <= ext_word_nx;
			seg_mode_q   <= seg_mode_nx;
			seg_base_q   <= seg_base_nx;
			lin_base_q   <= lin_base_nx;
			first_addr_q <= first_addr_nx;
			have_first_q <= have_first_nx;
			wptr_q       <= wptr_nx;
			max_ext_q    <= max_ext_nx;
		end
	end

	ihrl_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (emit),
		.res      (res),
		.can_load (can_load),
		.result   (result)
	);

endmodule
